// ===== rtl/cgs_pkg.sv =====
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared constants and types of the colour map gradient sampler.
// ----------------------------------------------------------------------------
package cgs_pkg;

  // Defaults for the top-level parameters
  localparam int MaxStopsDef     = 7;
  localparam int PositionBitsDef = 16;

  // Fixed field widths
  localparam int LevelW  = 16;
  localparam int ChanW   = 8;
  localparam int WordW   = 48;
  localparam int CountW  = 3;
  localparam int QuotW   = 8;
  localparam int AddrW   = 6;
  localparam int DataW   = 64;

  // Register indexes
  localparam logic [2:0] RegStopCount = 3'd0;
  localparam logic [2:0] RegStopWord0 = 3'd1;

  // Opaque black for an empty map
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Four channels packed red[31:24], green[23:16], blue[15:8], alpha[7:0]
  typedef logic [3:0][ChanW-1:0] rgba_t;

  // Control that travels with every pipeline stage
  typedef struct packed {
    logic valid;
    logic flat;
  } pipe_ctl_t;

endpackage

// ===== rtl/cgs_level_if.sv =====
// ----------------------------------------------------------------------------
// cgs_level_if
// Input channel: one normalized sample level per item.
// ----------------------------------------------------------------------------
interface cgs_level_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ===== rtl/cgs_colour_if.sv =====
// ----------------------------------------------------------------------------
// cgs_colour_if
// Output channel: one RGBA colour per item.
// ----------------------------------------------------------------------------
interface cgs_colour_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

// ===== rtl/colour_map_gradient_sampler.sv =====
// ----------------------------------------------------------------------------
// colour_map_gradient_sampler
// Piecewise linear RGBA colour map over up to MAX_STOPS configured stops.
//
//   channel  dir  handshake        payload
//   sample   in   valid/ready      level[15:0]
//   colour   out  valid/ready      red, green, blue, alpha [7:0]
//   apb      in   psel/penable     paddr[5:0], pwdata/prdata[63:0], pready=1
//
// One item enters per cycle unless colour stalls; the stages are segment select, dividend
// prep, eight one-bit division stages (set by the quotient width) and the output register.
// Reset (rst, synchronous) clears all valid bits and the configuration
// registers; pipeline data registers are left as they are.
// A stall on colour freezes the whole pipeline and holds sample.ready low.
// ----------------------------------------------------------------------------
module colour_map_gradient_sampler #(
  parameter int MAX_STOPS     = cgs_pkg::MaxStopsDef,
  parameter int POSITION_BITS = cgs_pkg::PositionBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  cgs_level_if.sink                   sample,
  cgs_colour_if.source                colour,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cgs_pkg::AddrW-1:0]   paddr,
  input  logic [cgs_pkg::DataW-1:0]   pwdata,
  output logic [cgs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import cgs_pkg::*;

  localparam int NumW = POSITION_BITS + 10;

  logic                              en;
  logic [2:0]                        stop_count;
  logic [MAX_STOPS-1:0][WordW-1:0]   stop_word;
  logic [2:0]                        reg_idx;
  logic                              wr;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite && pready;

  // Write a register; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
      stop_word  <= '0;
    end else if (wr) begin
      if (reg_idx == RegStopCount) begin
        stop_count <= pwdata[2:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (reg_idx == 3'(i + 1)) begin
          stop_word[i] <= pwdata[WordW-1:0];
        end
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == RegStopCount) begin
      prdata = DataW'(stop_count);
    end
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (reg_idx == 3'(i) + RegStopWord0) begin
        prdata = DataW'(stop_word[i]);
      end
    end
  end

  // ---------------- pipeline ----------------
  // Advance every stage unless the output is held
  assign en           = !colour.valid || colour.ready;
  assign sample.ready = en;

  pipe_ctl_t                    s1_ctl;
  rgba_t                        s1_col0;
  rgba_t                        s1_col1;
  logic [POSITION_BITS-1:0]     s1_off;
  logic [POSITION_BITS-1:0]     s1_rng;

  cgs_select #(.MAX_STOPS(MAX_STOPS), .POSITION_BITS(POSITION_BITS)) u_select (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sample.valid),
    .level      (sample.level),
    .stop_count (stop_count),
    .stop_word  (stop_word),
    .ctl        (s1_ctl),
    .col0       (s1_col0),
    .col1       (s1_col1),
    .off        (s1_off),
    .rng        (s1_rng)
  );

  pipe_ctl_t                    d_ctl  [QuotW+1];
  rgba_t                        d_col0 [QuotW+1];
  logic [3:0][NumW-1:0]         d_rem  [QuotW+1];
  logic [POSITION_BITS:0]       d_den  [QuotW+1];
  rgba_t                        d_q    [QuotW+1];

  cgs_prep #(.POSITION_BITS(POSITION_BITS)) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (s1_ctl),
    .col0_in (s1_col0),
    .col1_in (s1_col1),
    .off     (s1_off),
    .rng     (s1_rng),
    .ctl     (d_ctl[0]),
    .col0    (d_col0[0]),
    .rem     (d_rem[0]),
    .den     (d_den[0])
  );
  assign d_q[0] = '0;

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < QuotW; s++) begin : g_div
    cgs_div_stage #(.POSITION_BITS(POSITION_BITS), .BIT(QuotW - 1 - s)) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (d_ctl[s]),
      .col0_in (d_col0[s]),
      .rem_in  (d_rem[s]),
      .den_in  (d_den[s]),
      .q_in    (d_q[s]),
      .ctl     (d_ctl[s+1]),
      .col0    (d_col0[s+1]),
      .rem     (d_rem[s+1]),
      .den     (d_den[s+1]),
      .q       (d_q[s+1])
    );
  end

  // Output register: flat items take the chosen stop
  rgba_t out_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour.valid <= 1'b0;
    end else if (en) begin
      colour.valid <= d_ctl[QuotW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_col <= d_ctl[QuotW].flat ? d_col0[QuotW] : d_q[QuotW];
    end
  end

  assign colour.red   = out_col[3];
  assign colour.green = out_col[2];
  assign colour.blue  = out_col[1];
  assign colour.alpha = out_col[0];

  // ---------------- checks ----------------
  a_ready_tracks_output: assert property (@(posedge clk) disable iff (rst)
    sample.ready == (!colour.valid || colour.ready))
    else $error("input ready does not follow output stall");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !colour.valid)
    else $error("output valid set right after reset");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(d_ctl[QuotW].valid) && $stable(s1_ctl.valid))
    else $error("pipeline moved during a stall");

  a_write_takes_count: assert property (@(posedge clk) disable iff (rst)
    (wr && reg_idx == RegStopCount) |=> stop_count == $past(pwdata[2:0]))
    else $error("stop count write lost");

endmodule

// ===== rtl/cgs_select.sv =====
// ----------------------------------------------------------------------------
// cgs_select
// Stage one: compare the level against all stops and pick the segment.
// ----------------------------------------------------------------------------
module cgs_select #(
  parameter int MAX_STOPS     = 7,
  parameter int POSITION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [15:0]                               level,
  input  logic [2:0]                                stop_count,
  input  logic [MAX_STOPS-1:0][47:0]                stop_word,
  output cgs_pkg::pipe_ctl_t                        ctl,
  output cgs_pkg::rgba_t                            col0,
  output cgs_pkg::rgba_t                            col1,
  output logic [POSITION_BITS-1:0]                  off,
  output logic [POSITION_BITS-1:0]                  rng
);
  import cgs_pkg::*;

  localparam int IdxW = $clog2(MAX_STOPS);
  localparam logic [2:0] MaxCount = 3'(MAX_STOPS);

  logic [MAX_STOPS-1:0][POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] t;
  logic [2:0]      n;
  logic [IdxW-1:0] last;
  logic [IdxW-1:0] li;
  logic [IdxW-1:0] ri;
  logic            flat;
  logic            black;
  logic            found;

  // Cut positions and level to their top bits
  always_comb begin
    for (int i = 0; i < MAX_STOPS; i++) begin
      pos[i] = stop_word[i][47 -: POSITION_BITS];
    end
  end
  assign t    = level[15 -: POSITION_BITS];
  assign n    = (stop_count > MaxCount) ? MaxCount : stop_count;
  assign last = IdxW'(n - 3'd1);

  // Pick the left stop and whether to interpolate
  always_comb begin
    flat  = 1'b1;
    black = 1'b0;
    found = 1'b0;
    li    = '0;
    if (n == 3'd0) begin
      black = 1'b1;
    end else if (n == 3'd1 || t <= pos[0]) begin
      li = '0;
    end else if (t >= pos[last]) begin
      li = last;
    end else begin
      li = last;
      for (int i = 0; i < MAX_STOPS - 1; i++) begin
        if (!found && (3'(i + 1) < n) && t >= pos[i] && t <= pos[i+1]) begin
          found = 1'b1;
          flat  = 1'b0;
          li    = IdxW'(i);
        end
      end
    end
    ri = flat ? li : IdxW'(li + 1'b1);
  end

  // Register the chosen segment
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.flat <= flat;
      col0     <= black ? {8'd0, 8'd0, 8'd0, ChanMax} : stop_word[li][31:0];
      col1     <= stop_word[ri][31:0];
      off      <= t - pos[li];
      rng      <= pos[ri] - pos[li];
    end
  end

endmodule

// ===== rtl/cgs_prep.sv =====
// ----------------------------------------------------------------------------
// cgs_prep
// Stage two: form the rounded dividend and divisor for every channel.
// ----------------------------------------------------------------------------
module cgs_prep #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  cgs_pkg::pipe_ctl_t                     ctl_in,
  input  cgs_pkg::rgba_t                         col0_in,
  input  cgs_pkg::rgba_t                         col1_in,
  input  logic [POSITION_BITS-1:0]               off,
  input  logic [POSITION_BITS-1:0]               rng,
  output cgs_pkg::pipe_ctl_t                     ctl,
  output cgs_pkg::rgba_t                         col0,
  output logic [3:0][POSITION_BITS+9:0]          rem,
  output logic [POSITION_BITS:0]                 den
);
  import cgs_pkg::*;

  localparam int NumW = POSITION_BITS + 10;

  logic signed [NumW-1:0] prod_a [4];
  logic signed [NumW-1:0] prod_b [4];
  logic signed [NumW-1:0] numv   [4];
  logic signed [8:0]      diff   [4];
  logic [3:0][NumW-1:0]   rem_next;

  // num = c0*range + off*(c1-c0); dividend = 2*num + range
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k]   = $signed({1'b0, col1_in[k]}) - $signed({1'b0, col0_in[k]});
      prod_a[k] = $signed({{(NumW-8){1'b0}}, col0_in[k]})
                * $signed({{(NumW-POSITION_BITS){1'b0}}, rng});
      prod_b[k] = $signed({{(NumW-9){diff[k][8]}}, diff[k]})
                * $signed({{(NumW-POSITION_BITS){1'b0}}, off});
      numv[k]   = prod_a[k] + prod_b[k];
      rem_next[k] = NumW'({numv[k][NumW-2:0], 1'b0})
                  + NumW'({{(NumW-POSITION_BITS){1'b0}}, rng});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

  // Zero-width segment keeps the left stop
  always_ff @(posedge clk) begin
    if (en) begin
      ctl.flat <= ctl_in.flat || (rng == '0);
      col0     <= col0_in;
      rem      <= rem_next;
      den      <= {rng, 1'b0};
    end
  end

endmodule

// ===== rtl/cgs_div_stage.sv =====
// ----------------------------------------------------------------------------
// cgs_div_stage
// One restoring division step: settle one quotient bit for all channels.
// ----------------------------------------------------------------------------
module cgs_div_stage #(
  parameter int POSITION_BITS = 16,
  parameter int BIT           = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  cgs_pkg::pipe_ctl_t               ctl_in,
  input  cgs_pkg::rgba_t                   col0_in,
  input  logic [3:0][POSITION_BITS+9:0]    rem_in,
  input  logic [POSITION_BITS:0]           den_in,
  input  cgs_pkg::rgba_t                   q_in,
  output cgs_pkg::pipe_ctl_t               ctl,
  output cgs_pkg::rgba_t                   col0,
  output logic [3:0][POSITION_BITS+9:0]    rem,
  output logic [POSITION_BITS:0]           den,
  output cgs_pkg::rgba_t                   q
);
  import cgs_pkg::*;

  localparam int NumW = POSITION_BITS + 10;

  logic [NumW-1:0]      shifted;
  logic [3:0][NumW-1:0] rem_next;
  rgba_t                q_next;

  assign shifted = NumW'(den_in) << BIT;

  // Subtract the shifted divisor where it fits
  always_comb begin
    q_next = q_in;
    for (int k = 0; k < 4; k++) begin
      rem_next[k] = rem_in[k];
      if (rem_in[k] >= shifted) begin
        rem_next[k]     = rem_in[k] - shifted;
        q_next[k][BIT]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.flat <= ctl_in.flat;
      col0     <= col0_in;
      rem      <= rem_next;
      den      <= den_in;
      q        <= q_next;
    end
  end

endmodule
